### sv/uwcn_pkg.sv
// ----------------------------------------------------------------------------
// uwcn_pkg
// Shared types and constants of the UTF-8 whitespace/case normalizer.
// ----------------------------------------------------------------------------
package uwcn_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int MAX_RESULTS         = 5;

  // Byte classes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] CODE_CONT  = 8'h80;

  // Code point limits and case offsets
  localparam logic [20:0] CP_MAX1      = 21'h7F;
  localparam logic [20:0] CP_MAX2      = 21'h7FF;
  localparam logic [20:0] CP_MAX3      = 21'hFFFF;
  localparam logic [20:0] CP_UPPER_A   = 21'h41;
  localparam logic [20:0] CP_UPPER_Z   = 21'h5A;
  localparam logic [20:0] CP_CYR_IO    = 21'h401;
  localparam logic [20:0] CP_CYR_IO_LC = 21'h451;
  localparam logic [20:0] CP_CYR_IE_LC = 21'h435;
  localparam logic [20:0] CP_CYR_A     = 21'h410;
  localparam logic [20:0] CP_CYR_YA    = 21'h42F;
  localparam logic [20:0] CP_CYR_EXT_LO = 21'h400;
  localparam logic [20:0] CP_CYR_EXT_HI = 21'h40F;
  localparam logic [20:0] CASE_OFFSET  = 21'h20;
  localparam logic [20:0] EXT_OFFSET   = 21'h50;

  // Decoder partial-sequence state
  typedef struct packed {
    logic [2:0][7:0] pb;
    logic [1:0]      pcnt;
    logic [2:0]      slen;
  } dec_t;

  // Up to four bytes produced by one decode step
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } enc_t;

  typedef struct packed {
    dec_t st;
    enc_t e;
  } dec_res_t;

  // All result bytes caused by one input byte
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [2:0]                  n;
    logic                        last;
  } bundle_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_end;
  } res_t;

endpackage

### sv/utf8_whitespace_case_normalizer_unit.sv
// ----------------------------------------------------------------------------
// utf8_whitespace_case_normalizer_unit
// Collapses whitespace, lowercases UTF-8 text and re-encodes it, one byte in.
// ----------------------------------------------------------------------------
// Path: the first result of an input byte is written to the bundle queue when
//   the byte is taken, and from there is loaded into the output register.
// Throughput: one input byte per cycle while the queue has room; one result
//   per cycle out of the serializer while popped, so inputs that make several
//   results stall input once the QUEUE_DEPTH-entry bundle queue fills.
// Reset: synchronous rst empties queue and output, clears decoder state.
module utf8_whitespace_case_normalizer_unit
  import uwcn_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       text_end
);

  logic    q_push;
  logic    q_full;
  logic    q_empty;
  logic    deq;
  bundle_t q_wdata;
  bundle_t q_head;

  uwcn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .is_last (is_last),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  uwcn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (deq),
    .rd_data (q_head),
    .q_empty (q_empty)
  );

  uwcn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .deq      (deq),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .has_byte (has_byte),
    .run_last (run_last),
    .text_end (text_end)
  );

endmodule

### sv/uwcn_front.sv
// ----------------------------------------------------------------------------
// uwcn_front
// Collapses whitespace, decodes UTF-8, lowercases and re-encodes one input
// byte per cycle when not full, into a bundle of up to five result bytes.
// ----------------------------------------------------------------------------
module uwcn_front
  import uwcn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       q_push,
  output bundle_t    q_data,
  input  logic       q_full
);

  function automatic logic [20:0] lower_cp(logic [20:0] cp);
    logic [20:0] r;
    r = cp;
    if (cp >= CP_UPPER_A && cp <= CP_UPPER_Z) r = cp + CASE_OFFSET;
    else if (cp == CP_CYR_IO || cp == CP_CYR_IO_LC) r = CP_CYR_IE_LC;
    else if (cp >= CP_CYR_A && cp <= CP_CYR_YA) r = cp + CASE_OFFSET;
    else if (cp >= CP_CYR_EXT_LO && cp <= CP_CYR_EXT_HI) r = cp + EXT_OFFSET;
    return r;
  endfunction

  function automatic enc_t encode(logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= CP_MAX1) begin
      e.bytes[0] = cp[7:0];
      e.n = 3'd1;
    end else if (cp <= CP_MAX2) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.n = 3'd2;
    end else if (cp <= CP_MAX3) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.n = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.n = 3'd4;
    end
    return e;
  endfunction

  // Called with a cleared state; emits at most one byte
  function automatic dec_res_t start_seq(logic [7:0] b);
    dec_res_t   r;
    logic [2:0] len;
    r = '0;
    len = 3'd0;
    if (b < ASCII_TOP) begin
      r.e = encode(lower_cp({13'b0, b}));
    end else begin
      if ((b & MASK_LEAD2) == CODE_LEAD2) len = 3'd2;
      else if ((b & MASK_LEAD3) == CODE_LEAD3) len = 3'd3;
      else if ((b & MASK_LEAD4) == CODE_LEAD4) len = 3'd4;
      if (len == 3'd0) begin
        r.e.bytes[0] = b;
        r.e.n = 3'd1;
      end else begin
        r.st.pb[0] = b;
        r.st.pcnt = 2'd1;
        r.st.slen = len;
      end
    end
    return r;
  endfunction

  function automatic dec_res_t decode(dec_t st, logic [7:0] b);
    dec_res_t    r;
    dec_res_t    s;
    logic [20:0] cp;
    r = '0;
    cp = '0;
    if (st.slen == 3'd0 || st.pcnt == 2'd0) begin
      r = start_seq(b);
    end else if ((b & MASK_CONT) != CODE_CONT) begin
      // bad continuation: buffered bytes go out raw, b restarts decoding
      s = start_seq(b);
      r.st = s.st;
      r.e.bytes = {8'h00, st.pb[2], st.pb[1], st.pb[0]};
      if (s.e.n != 3'd0) r.e.bytes[st.pcnt] = s.e.bytes[0];
      r.e.n = {1'b0, st.pcnt} + s.e.n;
    end else if ({1'b0, st.pcnt} + 3'd1 >= st.slen) begin
      case (st.slen)
        3'd2:    cp = {10'b0, st.pb[0][4:0], b[5:0]};
        3'd3:    cp = {5'b0, st.pb[0][3:0], st.pb[1][5:0], b[5:0]};
        default: cp = {st.pb[0][2:0], st.pb[1][5:0], st.pb[2][5:0], b[5:0]};
      endcase
      r.e = encode(lower_cp(cp));
    end else begin
      r.st = st;
      r.st.pb[st.pcnt] = b;
      r.st.pcnt = st.pcnt + 2'd1;
    end
    return r;
  endfunction

  function automatic bundle_t append(bundle_t acc, enc_t e);
    bundle_t a;
    a = acc;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < e.n && a.n < 3'(MAX_RESULTS)) begin
        a.bytes[a.n] = e.bytes[k];
        a.n = a.n + 3'd1;
      end
    end
    return a;
  endfunction

  logic     after_space;
  logic     space_pending;
  dec_t     dec;
  logic     after_space_next;
  logic     space_pending_next;
  dec_t     dec_next;
  dec_res_t r_space;
  dec_res_t r_byte;
  enc_t     flush;
  bundle_t  acc;
  logic     is_ws;
  logic     accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign is_ws  = in_byte inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR};

  always_comb begin
    dec_next           = dec;
    after_space_next   = after_space;
    space_pending_next = space_pending;
    acc                = '0;
    r_space            = '0;
    r_byte             = '0;
    flush              = '0;
    if (is_ws) begin
      if (!after_space) begin
        space_pending_next = 1'b1;
        after_space_next   = 1'b1;
      end
    end else begin
      if (space_pending) begin
        r_space  = decode(dec_next, CHAR_SPACE);
        acc      = append(acc, r_space.e);
        dec_next = r_space.st;
        space_pending_next = 1'b0;
      end
      r_byte   = decode(dec_next, in_byte);
      acc      = append(acc, r_byte.e);
      dec_next = r_byte.st;
      after_space_next = 1'b0;
    end
    if (is_last) begin
      // end of text: emit a truncated sequence raw and start over
      flush.bytes = {8'h00, dec_next.pb[2], dec_next.pb[1], dec_next.pb[0]};
      flush.n     = {1'b0, dec_next.pcnt};
      acc         = append(acc, flush);
      dec_next    = '0;
      after_space_next   = 1'b1;
      space_pending_next = 1'b0;
    end
    acc.last = is_last;
  end

  assign q_push = accept && (acc.n != 3'd0 || is_last);
  assign q_data = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      after_space   <= 1'b1;
      space_pending <= 1'b0;
      dec           <= '0;
    end else if (accept) begin
      after_space   <= after_space_next;
      space_pending <= space_pending_next;
      dec           <= dec_next;
    end
  end

endmodule

### sv/uwcn_queue.sv
// ----------------------------------------------------------------------------
// uwcn_queue
// Small FIFO of result bundles between the decoder and the serializer.
// ----------------------------------------------------------------------------
module uwcn_queue
  import uwcn_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  bundle_t wr_data,
  output logic    q_full,
  input  logic    rd_en,
  output bundle_t rd_data,
  output logic    q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t        mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

### sv/uwcn_back.sv
// ----------------------------------------------------------------------------
// uwcn_back
// Walks each queued bundle one byte per cycle, if popped, to the output reg.
// ----------------------------------------------------------------------------
module uwcn_back
  import uwcn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    head,
  input  logic       q_empty,
  output logic       deq,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       text_end
);

  logic [2:0] idx;
  logic [2:0] res_cnt;
  logic       head_valid;
  logic       load;
  logic       pop_acc;
  logic       ov;
  res_t       ores;
  res_t       cur;

  assign head_valid = !q_empty;
  assign pop_acc    = pop && ov;
  assign load       = head_valid && (!ov || pop_acc);
  // a bare end marker still takes one result slot
  assign res_cnt    = (head.n == 3'd0) ? 3'd1 : head.n;

  always_comb begin
    cur.has_byte = (head.n != 3'd0);
    cur.out_byte = cur.has_byte ? head.bytes[idx] : 8'h00;
    cur.run_last = (idx == res_cnt - 3'd1);
    cur.text_end = cur.run_last && head.last;
  end

  assign deq = load && cur.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        ov  <= 1'b1;
        idx <= cur.run_last ? 3'd0 : idx + 3'd1;
      end else if (pop_acc) begin
        ov  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ores <= cur;
    end
  end

  assign empty    = !ov;
  assign out_byte = ores.out_byte;
  assign has_byte = ores.has_byte;
  assign run_last = ores.run_last;
  assign text_end = ores.text_end;

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < res_cnt)
    else $error("byte index past end of bundle");

  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    deq |=> idx == 3'd0)
    else $error("byte index not restarted after bundle");

  a_no_empty_bundle: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !head.last) |-> head.n != 3'd0)
    else $error("bundle without bytes for a non-final input");

  a_bundle_size: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.n <= 3'(MAX_RESULTS))
    else $error("bundle larger than allowed");

  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    (load && !cur.has_byte) |-> (cur.run_last && cur.text_end))
    else $error("bare end marker not closing the text");

endmodule
